[rtl/core/mbd_pkg.sv]
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types and constants for the multi-button debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbd_pkg;

    localparam int BUTTONS   = 16;
    localparam int IDX_W     = $clog2(BUTTONS);
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 16;
    localparam int HIST_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 72;

    localparam logic [HIST_W-1:0] HIST_ALL_ONES = 32'hFFFF_FFFF;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MIN_INTERVAL  = 2'd0;
    localparam logic [1:0] REG_HOLD_TICKS    = 2'd1;
    localparam logic [1:0] REG_SAMPLE_MASK   = 2'd2;
    localparam logic [1:0] REG_BUTTON_ENABLE = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0]   min_interval;
        logic [CNT_W-1:0]   hold_ticks;
        logic [HIST_W-1:0]  sample_mask;
        logic [BUTTONS-1:0] button_enable;
    } cfg_t;

    typedef struct packed {
        logic             load_in;
        logic             eval;
        logic             step;
        logic [IDX_W-1:0] idx;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic early;
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

[rtl/core/mbd_regs.sv]
// ----------------------------------------------------------------------------
// mbd_regs
// APB configuration registers of the debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbd_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output mbd_pkg::cfg_t              cfg
);
    import mbd_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval  <= '0;
            cfg_reg.hold_ticks    <= '0;
            cfg_reg.sample_mask   <= '0;
            cfg_reg.button_enable <= '1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_INTERVAL:  cfg_reg.min_interval  <= pwdata[CNT_W-1:0];
                REG_HOLD_TICKS:    cfg_reg.hold_ticks    <= pwdata[CNT_W-1:0];
                REG_SAMPLE_MASK:   cfg_reg.sample_mask   <= pwdata[HIST_W-1:0];
                REG_BUTTON_ENABLE: cfg_reg.button_enable <= pwdata[BUTTONS-1:0];
                default:           cfg_reg.min_interval  <= cfg_reg.min_interval;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_INTERVAL:  prdata = {16'd0, cfg_reg.min_interval};
            REG_HOLD_TICKS:    prdata = {16'd0, cfg_reg.hold_ticks};
            REG_SAMPLE_MASK:   prdata = cfg_reg.sample_mask;
            REG_BUTTON_ENABLE: prdata = {16'd0, cfg_reg.button_enable};
            default:           prdata = '0;
        endcase
    end

endmodule

[rtl/core/mbd_ctrl.sv]
// ----------------------------------------------------------------------------
// mbd_ctrl
// Sequencer: accept a poll, check interval, scan buttons unless early, hand off result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mbd_pkg::status_t  status,
    output mbd_pkg::cmd_t     cmd
);
    import mbd_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic             out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        cmd.load_in  = 1'b0;
        cmd.eval     = 1'b0;
        cmd.step     = 1'b0;
        cmd.idx      = idx_reg;
        cmd.load_out = 1'b0;

        if (valid_reg && m_tready)
            valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.eval = 1'b1;
                idx_next = '0;
                state_next = status.early ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(BUTTONS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[rtl/core/mbd_datapath.sv]
// ----------------------------------------------------------------------------
// mbd_datapath
// Poll registers, per-button history and lockout, debounced state, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbd_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mbd_pkg::cfg_t                  cfg,
    input  mbd_pkg::cmd_t                  cmd,
    output mbd_pkg::status_t               status,
    input  logic [mbd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic [mbd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mbd_pkg::*;

    logic [TIME_W-1:0]  now_reg;
    logic [BUTTONS-1:0] pins_reg;
    logic [TIME_W-1:0]  ticks_reg;
    logic [TIME_W-1:0]  last_reg;
    logic [BUTTONS-1:0] level_reg;
    logic [BUTTONS-1:0] held_reg;
    logic [BUTTONS-1:0] accum_reg;
    logic [BUTTONS-1:0] pressed_reg;
    logic [BUTTONS-1:0] released_reg;
    logic [BUTTONS-1:0] combo_reg;
    logic               acc_flag_reg;
    logic [HIST_W-1:0]  hist_reg [BUTTONS];
    logic [CNT_W-1:0]   lock_reg [BUTTONS];
    logic [OUT_DATA_W-1:0] out_reg;

    logic [TIME_W-1:0]  ticks;
    logic [CNT_W-1:0]   lk_cur;
    logic [CNT_W-1:0]   lk_dec;
    logic               en;
    logic               pin;
    logic [HIST_W-1:0]  hist_shift;
    logic [HIST_W-1:0]  hist_masked;
    logic               mask_zero;
    logic               lvl_ok;
    logic               new_level;
    logic               sampling;
    logic               change;
    logic [BUTTONS-1:0] bit_sel;
    logic [BUTTONS-1:0] held_cleared;

    assign ticks        = now_reg - last_reg;
    assign status.early = ticks < {16'd0, cfg.min_interval};

    assign lk_cur = lock_reg[cmd.idx];
    // lockout is 16 bits, so any elapsed time at or above 2^16 clears it
    assign lk_dec = ((ticks_reg[TIME_W-1:CNT_W] != '0) || (ticks_reg[CNT_W-1:0] >= lk_cur))
                    ? '0 : lk_cur - ticks_reg[CNT_W-1:0];

    assign en          = cfg.button_enable[cmd.idx];
    assign pin         = pins_reg[cmd.idx];
    assign hist_shift  = {hist_reg[cmd.idx][HIST_W-2:0], pin};
    assign hist_masked = hist_shift & cfg.sample_mask;
    assign mask_zero   = (cfg.sample_mask == '0);
    assign bit_sel     = BUTTONS'(1) << cmd.idx;
    assign held_cleared = held_reg & ~bit_sel;

    always_comb
    begin
        if (mask_zero)
        begin
            lvl_ok    = 1'b1;
            new_level = pin;
        end
        else if (hist_masked == '0)
        begin
            lvl_ok    = 1'b1;
            new_level = 1'b0;
        end
        else if (hist_masked == cfg.sample_mask)
        begin
            lvl_ok    = 1'b1;
            new_level = 1'b1;
        end
        else
        begin
            lvl_ok    = 1'b0;
            new_level = 1'b0;
        end
    end

    assign sampling = en && (lk_dec == '0);
    assign change   = sampling && lvl_ok && (new_level != level_reg[cmd.idx]);

    // poll capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            now_reg  <= s_tdata[TIME_W-1:0];
            pins_reg <= s_tdata[TIME_W +: BUTTONS];
        end
        if (cmd.eval)
            ticks_reg <= ticks;
        if (cmd.load_out)
            out_reg <= {7'd0, held_reg, combo_reg, released_reg, pressed_reg, acc_flag_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= '0;
            level_reg    <= '1;
            held_reg     <= '0;
            accum_reg    <= '0;
            pressed_reg  <= '0;
            released_reg <= '0;
            combo_reg    <= '0;
            acc_flag_reg <= 1'b0;
            for (int i = 0; i < BUTTONS; i++)
            begin
                hist_reg[i] <= HIST_ALL_ONES;
                lock_reg[i] <= '0;
            end
        end
        else if (cmd.eval)
        begin
            pressed_reg  <= '0;
            released_reg <= '0;
            combo_reg    <= '0;
            acc_flag_reg <= !status.early;
            if (!status.early)
                last_reg <= now_reg;
        end
        else if (cmd.step && en)
        begin
            lock_reg[cmd.idx] <= change ? cfg.hold_ticks : lk_dec;
            if (sampling && !mask_zero)
                hist_reg[cmd.idx] <= hist_shift;
            if (change)
            begin
                level_reg[cmd.idx] <= new_level;
                if (!new_level)
                begin
                    held_reg    <= held_reg | bit_sel;
                    pressed_reg <= pressed_reg | bit_sel;
                    accum_reg   <= accum_reg | bit_sel;
                end
                else
                begin
                    held_reg     <= held_cleared;
                    released_reg <= released_reg | bit_sel;
                    if (held_cleared == '0)
                    begin
                        combo_reg <= accum_reg;
                        accum_reg <= '0;
                    end
                end
            end
        end
    end

    assign m_tdata = out_reg;

endmodule

[rtl/core/multi_button_debouncer.sv]
// ----------------------------------------------------------------------------
// multi_button_debouncer
// Sixteen-button debouncer with history filter, lockout and combo report.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per poll, a timestamp and the raw active-low pin
//   levels. Master stream: one result item per poll (accepted flag, newly
//   pressed, newly released, combo and held masks).
//   APB port: min_interval at 0x0, hold_ticks at 0x4, sample_mask at 0x8,
//   button_enable at 0xC; write only while no poll is in flight.
// Timing:
//   After a poll is taken the sequencer checks the interval, the button
//   scan visits one button per cycle, and DONE loads the output register;
//   an early poll skips the scan. One shared per-button update unit serves
//   all buttons, so no new poll is taken before the last is in the output
//   register. s_tready is high only while the sequencer is idle.
// Reset: configuration returns to its defaults, histories to all ones,
//   lockouts and held/combo state to zero, no result pending.
// Stall: a result waits in the output register; the next poll is taken and
//   processed meanwhile, and only its hand-off waits for m_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_button_debouncer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] now_time, [47:32] pin_levels
    input  logic [mbd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] accepted, [16:1] pressed_mask, [32:17] released_mask,
    // [48:33] combo_mask, [64:49] held_mask, [71:65] zero
    output logic [mbd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mbd_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mbd_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    mbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mbd_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

[rtl/core/mbd_checker.sv]
// ----------------------------------------------------------------------------
// mbd_checker
// Port-level assertions for the debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mbd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mbd_pkg::*;

    // one poll in flight: busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a poll is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // early poll reports no edges and no combo
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[48:1] == '0)
        else $error("rejected poll reported events");

    // a button is visited once per poll
    a_no_press_and_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:1] & m_tdata[32:17]) == '0)
        else $error("button pressed and released in one poll");

    a_press_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:1] & ~m_tdata[64:49]) == '0)
        else $error("new press missing from held mask");

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (.*);
